@@ sv/scpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the SSTV pixel color assembly block.
// No dependencies; scpa_level, scpa_csc and the top level refer to it by scoped names.
package scpa_pkg;

	// Chroma line store
	localparam int MAX_PIXELS = 512;
	localparam int CHR_AW     = $clog2(MAX_PIXELS);

	// Field widths
	localparam int FREQ_W = 16;
	localparam int IDX_W  = 9;
	localparam int LVL_W  = 8;
	localparam int FMT_W  = 3;

	// Frequency to level: d = freq - 1500, level = (d*255 + 400) / 800
	localparam int D_W  = 10;
	localparam int N_W  = 18;
	localparam int M_W  = 13;
	localparam int P_W  = 26;
	localparam logic signed [FREQ_W:0] FREQ_BASE = 17'sd1500;
	// first d whose level would pass 255
	localparam logic signed [FREQ_W:0] SAT_D     = 17'sd802;
	localparam logic [N_W-1:0]         LVL_RND   = 18'd400;
	localparam int                     LVL_SH    = 8;
	// n / 800 = (n >> 5) / 25, and m / 25 = (m * 5243) >> 17 for m below 8192
	localparam logic [M_W-1:0]         RECIP     = 13'd5243;
	localparam int                     RECIP_SH  = 17;
	localparam logic [LVL_W-1:0]       LVL_MAX   = 8'hFF;

	// Color conversion
	localparam int CSC_W = 18;
	localparam int SUM_W = 10;
	localparam int CSC_SH = 8;
	localparam logic signed [8:0]       CHROMA_MID = 9'sd128;
	localparam logic signed [CSC_W-1:0] COEF_RV = 18'sd351;
	localparam logic signed [CSC_W-1:0] COEF_GV = 18'sd179;
	localparam logic signed [CSC_W-1:0] COEF_GU = 18'sd86;
	localparam logic signed [CSC_W-1:0] COEF_BU = 18'sd443;

	// Color format codes; 4 to 7 give black
	localparam logic [FMT_W-1:0] FMT_ALT_YUV = 3'd0;
	localparam logic [FMT_W-1:0] FMT_GBR     = 3'd1;
	localparam logic [FMT_W-1:0] FMT_YUV     = 3'd2;
	localparam logic [FMT_W-1:0] FMT_RGB     = 3'd3;
	localparam logic [FMT_W-1:0] FMT_RESET   = FMT_GBR;

	// Register map
	localparam int         APB_AW           = 3;
	localparam logic [0:0] REG_COLOR_FORMAT = 1'b0;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} lvl_en_t;

	typedef struct packed {
		logic s4;
		logic s5;
	} csc_en_t;

	function automatic logic [CHR_AW-1:0] chroma_addr(input logic [IDX_W-1:0] idx);
		return CHR_AW'(idx);
	endfunction

	function automatic logic chroma_inside(input logic [IDX_W-1:0] idx);
		return 32'(idx) < MAX_PIXELS;
	endfunction

	function automatic logic [LVL_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
		logic [LVL_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > SUM_W'(LVL_MAX)) begin
			r = LVL_MAX;
		end else begin
			r = x[LVL_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/scpa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-first: a same-cycle write is seen on the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/scpa_level.sv @@
`timescale 1ns / 1ps
// One channel's frequency-to-level pipeline, stages s1 to s3.
// Depends on scpa_pkg.
module scpa_level (
	input  logic                              clk,
	input  scpa_pkg::lvl_en_t                 en,
	input  logic signed [scpa_pkg::FREQ_W-1:0] freq,
	input  logic                              ok,
	output logic [scpa_pkg::LVL_W-1:0]        level_nxt,
	output logic [scpa_pkg::LVL_W-1:0]        level_s3
);

	logic signed [scpa_pkg::FREQ_W:0] diff;
	logic                             zero_nxt;
	logic                             sat_nxt;

	logic                       zero_s1;
	logic                       sat_s1;
	logic [scpa_pkg::D_W-1:0]   d_s1;
	logic [scpa_pkg::N_W-1:0]   num;

	logic                       zero_s2;
	logic                       sat_s2;
	logic [scpa_pkg::M_W-1:0]   m_s2;
	logic [scpa_pkg::P_W-1:0]   prod;

	// offset from the black tone; negative or invalid gives zero
	assign diff     = $signed({freq[scpa_pkg::FREQ_W-1], freq}) - scpa_pkg::FREQ_BASE;
	assign zero_nxt = !ok || diff[scpa_pkg::FREQ_W];
	assign sat_nxt  = diff >= scpa_pkg::SAT_D;

	// d*255 + 400, then drop the factor 32 of 800
	assign num = (scpa_pkg::N_W'(d_s1) << scpa_pkg::LVL_SH) - scpa_pkg::N_W'(d_s1)
		+ scpa_pkg::LVL_RND;

	// divide by 25 through the reciprocal
	assign prod = scpa_pkg::P_W'(m_s2) * scpa_pkg::P_W'(scpa_pkg::RECIP);

	always_comb begin
		if (zero_s2) begin
			level_nxt = '0;
		end else if (sat_s2) begin
			level_nxt = scpa_pkg::LVL_MAX;
		end else begin
			level_nxt = prod[scpa_pkg::RECIP_SH+scpa_pkg::LVL_W-1:scpa_pkg::RECIP_SH];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			zero_s1 <= zero_nxt;
			sat_s1  <= sat_nxt;
			d_s1    <= diff[scpa_pkg::D_W-1:0];
		end
		if (en.s2) begin
			zero_s2 <= zero_s1;
			sat_s2  <= sat_s1;
			m_s2    <= num[scpa_pkg::N_W-1:scpa_pkg::N_W-scpa_pkg::M_W];
		end
		if (en.s3) begin
			level_s3 <= level_nxt;
		end
	end

endmodule

@@ sv/scpa_csc.sv @@
`timescale 1ns / 1ps
// Color arrangement and YUV-to-RGB conversion, stages s4 and s5.
// Depends on scpa_pkg.
module scpa_csc (
	input  logic                           clk,
	input  scpa_pkg::csc_en_t              en,
	input  logic [scpa_pkg::FMT_W-1:0]     fmt,
	input  logic                           odd_s3,
	input  logic [scpa_pkg::LVL_W-1:0]     c0_s3,
	input  logic [scpa_pkg::LVL_W-1:0]     c1_s3,
	input  logic [scpa_pkg::LVL_W-1:0]     c2_s3,
	input  logic [scpa_pkg::LVL_W-1:0]     stored_s3,
	output logic [scpa_pkg::LVL_W-1:0]     blue,
	output logic [scpa_pkg::LVL_W-1:0]     green,
	output logic [scpa_pkg::LVL_W-1:0]     red
);

	logic [scpa_pkg::LVL_W-1:0] u_sel;
	logic [scpa_pkg::LVL_W-1:0] v_sel;
	logic signed [8:0]          uc;
	logic signed [8:0]          vc;

	logic [scpa_pkg::LVL_W-1:0]       y_s4;
	logic [scpa_pkg::LVL_W-1:0]       c0_s4;
	logic [scpa_pkg::LVL_W-1:0]       c1_s4;
	logic [scpa_pkg::LVL_W-1:0]       c2_s4;
	logic signed [scpa_pkg::CSC_W-1:0] pr_s4;
	logic signed [scpa_pkg::CSC_W-1:0] pg_s4;
	logic signed [scpa_pkg::CSC_W-1:0] pb_s4;

	logic signed [scpa_pkg::SUM_W-1:0] y_ext;
	logic signed [scpa_pkg::SUM_W-1:0] r_sum;
	logic signed [scpa_pkg::SUM_W-1:0] g_sum;
	logic signed [scpa_pkg::SUM_W-1:0] b_sum;
	logic [scpa_pkg::LVL_W-1:0]       blue_nxt;
	logic [scpa_pkg::LVL_W-1:0]       green_nxt;
	logic [scpa_pkg::LVL_W-1:0]       red_nxt;

	// chroma pick: alternating lines swap the live and stored chroma
	always_comb begin
		if (fmt == scpa_pkg::FMT_ALT_YUV) begin
			u_sel = odd_s3 ? c1_s3 : stored_s3;
			v_sel = odd_s3 ? stored_s3 : c1_s3;
		end else begin
			u_sel = c2_s3;
			v_sel = c1_s3;
		end
	end

	assign uc = $signed({1'b0, u_sel}) - scpa_pkg::CHROMA_MID;
	assign vc = $signed({1'b0, v_sel}) - scpa_pkg::CHROMA_MID;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4  <= c0_s3;
			c0_s4 <= c0_s3;
			c1_s4 <= c1_s3;
			c2_s4 <= c2_s3;
			pr_s4 <= scpa_pkg::CSC_W'(vc) * scpa_pkg::COEF_RV;
			pg_s4 <= scpa_pkg::CSC_W'(vc) * scpa_pkg::COEF_GV
				+ scpa_pkg::CSC_W'(uc) * scpa_pkg::COEF_GU;
			pb_s4 <= scpa_pkg::CSC_W'(uc) * scpa_pkg::COEF_BU;
		end
	end

	// arithmetic shift floors the product scaling
	assign y_ext = scpa_pkg::SUM_W'($signed({1'b0, y_s4}));
	assign r_sum = y_ext + scpa_pkg::SUM_W'(pr_s4 >>> scpa_pkg::CSC_SH);
	assign g_sum = y_ext - scpa_pkg::SUM_W'(pg_s4 >>> scpa_pkg::CSC_SH);
	assign b_sum = y_ext + scpa_pkg::SUM_W'(pb_s4 >>> scpa_pkg::CSC_SH);

	always_comb begin
		unique case (fmt)
			scpa_pkg::FMT_ALT_YUV, scpa_pkg::FMT_YUV: begin
				blue_nxt  = scpa_pkg::clamp8(b_sum);
				green_nxt = scpa_pkg::clamp8(g_sum);
				red_nxt   = scpa_pkg::clamp8(r_sum);
			end
			scpa_pkg::FMT_GBR: begin
				blue_nxt  = c1_s4;
				green_nxt = c0_s4;
				red_nxt   = c2_s4;
			end
			scpa_pkg::FMT_RGB: begin
				blue_nxt  = c2_s4;
				green_nxt = c1_s4;
				red_nxt   = c0_s4;
			end
			default: begin
				blue_nxt  = '0;
				green_nxt = '0;
				red_nxt   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			blue  <= blue_nxt;
			green <= green_nxt;
			red   <= red_nxt;
		end
	end

endmodule

@@ sv/sstv_pixel_color_assembly_top.sv @@
`timescale 1ns / 1ps
// Top level of the SSTV pixel color assembly block: control, chroma store, register port.
// Depends on scpa_pkg, scpa_ram, scpa_level and scpa_csc.

// Turns one pixel's three measured tone frequencies into one BMP pixel (blue, green,
// red). Each frequency maps to a level 0..255 from 1500 Hz up in steps of 800/255 Hz;
// a channel flagged invalid in window_ok reads as 0. color_format picks the layout:
// 0 alternating-line YUV, where the chroma of the previous line is kept per pixel in
// a 512-entry store, 1 GBR, 2 three-channel YUV, 3 RGB, 4..7 black. The datapath is
// a five-stage pipeline (three stages for the level, two for color conversion) and
// takes one item per clock while in_stall is low; a result shows on out_valid when its
// item reaches s5, and out_stall holds the whole pipe only as far back as it
// is full. The chroma store is read one stage before it is written, and a same-edge
// read of the entry being written picks up the new value, so consecutive pixels on
// any index pattern are exact. After reset the store is cleared, one entry a clock;
// in_stall stays high during that pass while register writes are taken as usual.
// Change color_format only while no item is in flight.
module sstv_pixel_color_assembly_top (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scpa_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [scpa_pkg::FREQ_W-1:0] chan0_freq,
	input  logic signed [scpa_pkg::FREQ_W-1:0] chan1_freq,
	input  logic signed [scpa_pkg::FREQ_W-1:0] chan2_freq,
	input  logic [2:0]                        window_ok,
	input  logic [scpa_pkg::IDX_W-1:0]        pixel_index,
	input  logic                              line_odd,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [scpa_pkg::LVL_W-1:0]        blue,
	output logic [scpa_pkg::LVL_W-1:0]        green,
	output logic [scpa_pkg::LVL_W-1:0]        red
);

	// configuration
	logic [scpa_pkg::FMT_W-1:0] fmt_q;
	logic                       cfg_wr;

	// store clearing pass
	logic                        clearing_q;
	logic [scpa_pkg::CHR_AW-1:0] clr_cnt_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;
	scpa_pkg::lvl_en_t lvl_en;
	scpa_pkg::csc_en_t csc_en;

	// sideband carried with the item
	logic [scpa_pkg::IDX_W-1:0] idx_s1, idx_s2;
	logic                       odd_s1, odd_s2, odd_s3;
	logic                       inside_s2;

	// chroma store access
	logic                        item_we;
	logic                        ram_we;
	logic [scpa_pkg::CHR_AW-1:0] ram_waddr;
	logic [scpa_pkg::LVL_W-1:0]  ram_wdata;
	logic [scpa_pkg::LVL_W-1:0]  ram_rdata;
	logic                        byp_q;
	logic [scpa_pkg::LVL_W-1:0]  byp_data_q;
	logic [scpa_pkg::LVL_W-1:0]  stored_s2;
	logic [scpa_pkg::LVL_W-1:0]  stored_s3;

	// levels
	logic [scpa_pkg::LVL_W-1:0] lvl0_nxt, lvl1_nxt, lvl2_nxt;
	logic [scpa_pkg::LVL_W-1:0] lvl0_s3, lvl1_s3, lvl2_s3;

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == scpa_pkg::REG_COLOR_FORMAT) ? 32'(fmt_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= scpa_pkg::FMT_RESET;
		end else if (cfg_wr && paddr[2] == scpa_pkg::REG_COLOR_FORMAT) begin
			fmt_q <= pwdata[scpa_pkg::FMT_W-1:0];
		end
	end

	// ---------------- clearing pass ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == scpa_pkg::CHR_AW'(scpa_pkg::MAX_PIXELS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// ---------------- pipeline control ----------------
	// a stage loads when it is empty or its contents move on
	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_stall  = clearing_q || !rdy1;
	assign accept    = in_valid && !in_stall;
	assign out_valid = v_s5;

	assign lvl_en = '{s1: rdy1, s2: rdy2, s3: rdy3};
	assign csc_en = '{s4: rdy4, s5: rdy5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= accept;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			idx_s1 <= pixel_index;
			odd_s1 <= line_odd;
		end
		if (rdy2) begin
			idx_s2 <= idx_s1;
			odd_s2 <= odd_s1;
		end
		if (rdy3) begin
			odd_s3    <= odd_s2;
			stored_s3 <= stored_s2;
		end
	end

	// ---------------- level units ----------------
	scpa_level u_lvl0 (
		.clk       (clk),
		.en        (lvl_en),
		.freq      (chan0_freq),
		.ok        (window_ok[0]),
		.level_nxt (lvl0_nxt),
		.level_s3  (lvl0_s3)
	);

	scpa_level u_lvl1 (
		.clk       (clk),
		.en        (lvl_en),
		.freq      (chan1_freq),
		.ok        (window_ok[1]),
		.level_nxt (lvl1_nxt),
		.level_s3  (lvl1_s3)
	);

	scpa_level u_lvl2 (
		.clk       (clk),
		.en        (lvl_en),
		.freq      (chan2_freq),
		.ok        (window_ok[2]),
		.level_nxt (lvl2_nxt),
		.level_s3  (lvl2_s3)
	);

	// ---------------- chroma store ----------------
	// read as the item enters s2, write channel 1's level as it leaves s2
	assign inside_s2 = scpa_pkg::chroma_inside(idx_s2);
	assign item_we   = rdy3 && v_s2 && !clearing_q
		&& fmt_q == scpa_pkg::FMT_ALT_YUV && inside_s2;
	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : scpa_pkg::chroma_addr(idx_s2);
	assign ram_wdata = clearing_q ? '0 : lvl1_nxt;

	scpa_ram #(
		.WIDTH (scpa_pkg::LVL_W),
		.DEPTH (scpa_pkg::MAX_PIXELS)
	) u_chroma_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rdy2),
		.raddr (scpa_pkg::chroma_addr(idx_s1)),
		.rdata (ram_rdata)
	);

	// forward a write that lands on the entry being read at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rdy2) begin
			byp_q <= item_we
				&& scpa_pkg::chroma_addr(idx_s1) == scpa_pkg::chroma_addr(idx_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			byp_data_q <= lvl1_nxt;
		end
	end

	always_comb begin
		if (!inside_s2) begin
			stored_s2 = '0;
		end else if (byp_q) begin
			stored_s2 = byp_data_q;
		end else begin
			stored_s2 = ram_rdata;
		end
	end

	// ---------------- color conversion ----------------
	scpa_csc u_csc (
		.clk       (clk),
		.en        (csc_en),
		.fmt       (fmt_q),
		.odd_s3    (odd_s3),
		.c0_s3     (lvl0_s3),
		.c1_s3     (lvl1_s3),
		.c2_s3     (lvl2_s3),
		.stored_s3 (stored_s3),
		.blue      (blue),
		.green     (green),
		.red       (red)
	);

	// ---------------- assertions ----------------
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> in_stall)
		else $error("item accepted during store clearing");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item missing from stage 1");

	a_stall_holds_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && out_stall && v_s4 |=> v_s4 && v_s5)
		else $error("item dropped behind a stalled result");

	a_item_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		item_we |-> fmt_q == scpa_pkg::FMT_ALT_YUV && v_s2)
		else $error("chroma store written outside alternating YUV");

endmodule
